// ===== rtl/core/swr_pkg.sv =====
`default_nettype none

package swr_pkg;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned QDepth    = 2;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_SYNACK  = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] seq;
    logic       syn;
    logic       em;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] peer;
    logic [7:0] seq;
    logic       fem;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/swr_front.sv =====
`default_nettype none

module swr_front #(
  parameter int unsigned NUM_SENDERS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 crc_ok_i,
  input  wire logic [7:0]           dest_node_i,
  input  wire logic [7:0]           source_node_i,
  input  wire logic [7:0]           frame_seq_i,
  input  wire logic                 is_syn_i,
  input  wire logic                 ends_message_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output swr_pkg::item_t            item_o
);
  import swr_pkg::*;

  logic [7:0] rid_q;
  logic       keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q <= 8'd0;
    end else if (cfg_valid_i) begin
      rid_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // bad CRC, foreign destination and unknown senders end here
  assign keep = crc_ok_i && (dest_node_i == rid_q) &&
                ({1'b0, source_node_i} < 9'(NUM_SENDERS));

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  assign item_o.src = source_node_i;
  assign item_o.seq = frame_seq_i;
  assign item_o.syn = is_syn_i;
  assign item_o.em  = ends_message_i;

endmodule

`default_nettype wire

// ===== rtl/core/swr_fifo.sv =====
`default_nettype none

module swr_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire swr_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output swr_pkg::item_t      item_o
);
  import swr_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  item_t             ent_q [QDepth];
  logic [PtrW:0]     wr_q, wr_d, rd_q, rd_d;

  assign full_o  = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign item_o  = ent_q[rd_q[PtrW-1:0]];

  assign wr_d = (push_i && !full_o) ? wr_q + (PtrW+1)'(1) : wr_q;
  assign rd_d = (pop_i && valid_o) ? rd_q + (PtrW+1)'(1) : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      ent_q[wr_q[PtrW-1:0]] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swr_back.sv =====
`default_nettype none

module swr_back #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned NUM_SENDERS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire swr_pkg::item_t item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output swr_pkg::result_t    res_o
);
  import swr_pkg::*;

  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SndW  = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned RowW  = 8 + 2 * WINDOW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_DLV    = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;
  localparam logic [2:0] ST_ACK    = 3'd4;
  localparam logic [2:0] ST_SYNACK = 3'd5;

  function automatic logic [256*SlotW-1:0] build_slot_lut();
    logic [256*SlotW-1:0] lut;
    lut = '0;
    for (int i = 0; i < 256; i++) begin
      lut[i*SlotW +: SlotW] = SlotW'(i % WINDOW);
    end
    return lut;
  endfunction

  localparam logic [256*SlotW-1:0] SlotLut = build_slot_lut();

  function automatic logic [SlotW-1:0] slot_of(input logic [7:0] s);
    return SlotLut[s*SlotW +: SlotW];
  endfunction

  // per-sender row: last received seq, slot full bits, slot end-of-message bits
  logic [RowW-1:0]        row_mem [NUM_SENDERS];
  logic [RowW-1:0]        row_q;

  logic [2:0]             state_q, state_d;
  logic [NUM_SENDERS-1:0] conn_q, conn_d;
  logic [7:0]             src_q, seq_q;
  logic                   syn_q, em_q;
  logic [7:0]             lr_q, lr_d;
  logic [WINDOW-1:0]      full_q, full_d, emb_q, emb_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  result_t                out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   room, emit, mem_we;
  result_t                res;
  logic [7:0]             lr_r, diff;
  logic [WINDOW-1:0]      full_r, em_r;
  logic [SlotW-1:0]       seq_slot, lr_slot, cur_slot, nxt_slot;

  assign room   = !out_valid_q || out_ready_i;
  assign pop_o  = (state_q == ST_IDLE) && valid_i;

  assign lr_r   = row_q[RowW-1 -: 8];
  assign full_r = row_q[2*WINDOW-1:WINDOW];
  assign em_r   = row_q[WINDOW-1:0];
  assign diff   = seq_q - lr_r;

  assign seq_slot = slot_of(seq_q);
  assign lr_slot  = slot_of(lr_r);
  assign cur_slot = slot_of(lr_q);
  assign nxt_slot = slot_of(lr_q + 8'd1);

  always_comb begin
    state_d = state_q;
    conn_d  = conn_q;
    lr_d    = lr_q;
    full_d  = full_q;
    emb_d   = emb_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    mem_we  = 1'b0;
    res.kind = KIND_ACK;
    res.peer = src_q;
    res.seq  = lr_q;
    res.fem  = 1'b0;
    res.last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        full_d = full_r;
        emb_d  = em_r;
        lr_d   = lr_r;
        cnt_d  = '0;
        if (!conn_q[src_q[SndW-1:0]]) begin
          if (syn_q) begin
            conn_d[src_q[SndW-1:0]] = 1'b1;
            lr_d             = 8'd0;
            full_d           = '0;
            full_d[seq_slot] = 1'b1;
            emb_d[seq_slot]  = em_q;
            state_d          = ST_SYNACK;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (diff == 8'd1) begin
          full_d[lr_slot]  = 1'b0;
          full_d[seq_slot] = 1'b1;
          emb_d[seq_slot]  = em_q;
          lr_d             = seq_q;
          state_d          = ST_DLV;
        end else begin
          if (diff >= 8'd2 && diff <= 8'(WINDOW) && !full_r[seq_slot]) begin
            full_d[seq_slot] = 1'b1;
            emb_d[seq_slot]  = em_q;
          end
          state_d = ST_ACK;
        end
      end
      ST_DLV: begin
        res.kind = KIND_DELIVER;
        res.fem  = emb_q[cur_slot];
        if (room) begin
          emit = 1'b1;
          if (cnt_q < CntW'(WINDOW) && full_q[nxt_slot]) begin
            full_d[cur_slot] = 1'b0;
            lr_d             = lr_q + 8'd1;
            cnt_d            = cnt_q + CntW'(1);
          end else if (full_q[cur_slot] && emb_q[cur_slot]) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_DONE: begin
        res.kind = KIND_DONE;
        if (room) begin
          emit             = 1'b1;
          full_d[cur_slot] = 1'b0;
          state_d          = ST_ACK;
        end
      end
      ST_ACK: begin
        res.last = 1'b1;
        if (room) begin
          emit    = 1'b1;
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SYNACK: begin
        res.kind = KIND_SYNACK;
        res.seq  = seq_q;
        res.last = 1'b1;
        if (room) begin
          emit    = 1'b1;
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      conn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      conn_q      <= conn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q   <= lr_d;
    full_q <= full_d;
    emb_q  <= emb_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
    if (pop_o) begin
      src_q <= item_i.src;
      seq_q <= item_i.seq;
      syn_q <= item_i.syn;
      em_q  <= item_i.em;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[src_q[SndW-1:0]] <= {lr_q, full_q, emb_q};
    end
    if (pop_o) begin
      row_q <= row_mem[item_i.src[SndW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_receiver.sv =====
// Selective-repeat receive window with one window per sender.
// cfg channel: cfg_data_i is the own node id; always ready, write only when idle.
// s_axis: one frame header per transfer. Frames with a bad CRC, another
//   destination or a sender id at or above NUM_SENDERS are taken and dropped
//   in the accept cycle.
// m_axis: result items; tuser is the kind, tlast marks the last result of a frame.
// A kept frame enters a 2-entry queue; the engine pops it and reads the
//   per-sender row into a register, evaluates the frame, then emits its
//   results into the registered m_axis stage, one result per cycle while m_axis
//   is not stalled. Each kept frame yields 1..WINDOW+2 results; the engine reads,
//   modifies and writes back the sender row and pops the next frame only after
//   its last result. A frame from an unconnected sender without SYN yields none.
// Reset: every sender is disconnected and the node id is 0; no clearing pass,
//   the connected bits gate the per-sender rows.
// Stall: m_axis holds its result while tready is low, the engine waits, the
//   queue fills and then s_axis_tready drops.
`default_nettype none

module sliding_window_receiver #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned NUM_SENDERS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [7:0]                     cfg_data_i,    // receiver_id
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // crc_ok[0], dest_node[8:1], source_node[16:9], frame_seq[24:17], zero[31:25]
  input  wire logic [swr_pkg::InTdataW-1:0]   s_axis_tdata,
  input  wire logic                           s_axis_tuser,  // is_syn
  input  wire logic                           s_axis_tlast,  // ends_message
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // peer_node[7:0], result_seq[15:8], frame_ends_message[16], zero[23:17]
  output logic [swr_pkg::OutTdataW-1:0]       m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // kind
  output logic                                m_axis_tlast   // last_result
);
  import swr_pkg::*;

  logic    q_full, push, q_valid, pop;
  item_t   push_item, head_item;
  result_t res;

  swr_front #(
    .NUM_SENDERS(NUM_SENDERS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .crc_ok_i      (s_axis_tdata[0]),
    .dest_node_i   (s_axis_tdata[8:1]),
    .source_node_i (s_axis_tdata[16:9]),
    .frame_seq_i   (s_axis_tdata[24:17]),
    .is_syn_i      (s_axis_tuser),
    .ends_message_i(s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  swr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  swr_back #(
    .WINDOW     (WINDOW),
    .NUM_SENDERS(NUM_SENDERS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (head_item),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {7'd0, res.fem, res.seq, res.peer};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/core/swr_checker.sv =====
`default_nettype none

module swr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [swr_pkg::OutTdataW-1:0] m_axis_tdata,
  input wire logic [1:0]                    m_axis_tuser,
  input wire logic                          m_axis_tlast
);
  import swr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_ACK ||
                                        m_axis_tuser == KIND_SYNACK)))
    else $error("tlast does not match result kind");

  a_mark_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_DELIVER) |-> !m_axis_tdata[16])
    else $error("end-of-message mark on a non-deliver result");

  a_done_then_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_DONE) |=>
      (!m_axis_tvalid || m_axis_tuser == KIND_ACK))
    else $error("message complete not followed by ack");

endmodule

bind sliding_window_receiver swr_checker u_swr_checker (.*);

`default_nettype wire
